// ===== hw/rtl/dcd_pkg.sv =====
// Shared types and constants for the detector candidate decoder.
`timescale 1ns / 1ps

package dcd_pkg;

    localparam int COORD_W         = 16;
    localparam int SCORE_W         = 16;
    localparam int SCALE_W         = 16;
    localparam int PAD_W           = 12;
    localparam int DIM_W           = 13;
    localparam int PIX_W           = 12;
    localparam int CLASS_W         = 9;
    localparam int POS_W           = 8;
    localparam int SCALE_FRAC_BITS = 12;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE   = 16'd4096;
    localparam logic [PAD_W-1:0]   RST_PADDING         = 12'd0;
    localparam logic [DIM_W-1:0]   RST_IMAGE_DIM       = 13'd640;
    localparam logic [DIM_W-1:0]   DIM_MAX             = 13'd4096;

    localparam logic signed [CLASS_W-1:0] NO_CLASS = -9'sd1;

    typedef enum logic [2:0] {
        REG_SCORE_THRESHOLD    = 3'd0,
        REG_INVERSE_SCALE      = 3'd1,
        REG_PADDING_HORIZONTAL = 3'd2,
        REG_PADDING_VERTICAL   = 3'd3,
        REG_IMAGE_WIDTH        = 3'd4,
        REG_IMAGE_HEIGHT       = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] score_threshold;
        logic [SCALE_W-1:0] inverse_scale;
        logic [PAD_W-1:0]   padding_horizontal;
        logic [PAD_W-1:0]   padding_vertical;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } t_cfg;

    typedef struct packed {
        logic signed [CLASS_W-1:0] kept_class;
        logic [SCORE_W-1:0]        kept_score;
        logic [COORD_W-1:0]        centre_x;
        logic [COORD_W-1:0]        centre_y;
        logic [COORD_W-1:0]        box_w;
        logic [COORD_W-1:0]        box_h;
    } t_cand;

endpackage

// ===== hw/rtl/dcd_if.sv =====
// Stream interfaces for candidate scores in and decoded boxes out.
`timescale 1ns / 1ps

interface dcd_cand_if;
    logic                        valid;
    logic                        ready;
    logic [dcd_pkg::COORD_W-1:0] centre_x;
    logic [dcd_pkg::COORD_W-1:0] centre_y;
    logic [dcd_pkg::COORD_W-1:0] box_w;
    logic [dcd_pkg::COORD_W-1:0] box_h;
    logic [dcd_pkg::SCORE_W-1:0] class_score;
    logic                        last_class;

    modport source (output valid, centre_x, centre_y, box_w, box_h, class_score, last_class,
                    input ready);
    modport sink   (input valid, centre_x, centre_y, box_w, box_h, class_score, last_class,
                    output ready);
endinterface

interface dcd_box_if;
    logic                               valid;
    logic                               ready;
    logic signed [dcd_pkg::CLASS_W-1:0] kept_class;
    logic [dcd_pkg::SCORE_W-1:0]        kept_score;
    logic [dcd_pkg::PIX_W-1:0]          left_px;
    logic [dcd_pkg::PIX_W-1:0]          top_px;
    logic [dcd_pkg::PIX_W-1:0]          width_px;
    logic [dcd_pkg::PIX_W-1:0]          height_px;

    modport source (output valid, kept_class, kept_score, left_px, top_px, width_px, height_px,
                    input ready);
    modport sink   (input valid, kept_class, kept_score, left_px, top_px, width_px, height_px,
                    output ready);
endinterface

// ===== hw/rtl/dcd_regs.sv =====
// APB configuration register file for the candidate decoder.
`timescale 1ns / 1ps

module dcd_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [dcd_pkg::DATA_W-1:0]   pwdata,
    output logic [dcd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output dcd_pkg::t_cfg                o_cfg
);

    dcd_pkg::t_cfg    r_cfg;
    dcd_pkg::t_cfg    n_cfg;
    dcd_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = dcd_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                dcd_pkg::REG_SCORE_THRESHOLD:
                    n_cfg.score_threshold = pwdata[dcd_pkg::SCORE_W-1:0];
                dcd_pkg::REG_INVERSE_SCALE:
                    n_cfg.inverse_scale = pwdata[dcd_pkg::SCALE_W-1:0];
                dcd_pkg::REG_PADDING_HORIZONTAL:
                    n_cfg.padding_horizontal = pwdata[dcd_pkg::PAD_W-1:0];
                dcd_pkg::REG_PADDING_VERTICAL:
                    n_cfg.padding_vertical = pwdata[dcd_pkg::PAD_W-1:0];
                dcd_pkg::REG_IMAGE_WIDTH:
                    n_cfg.image_width = pwdata[dcd_pkg::DIM_W-1:0];
                dcd_pkg::REG_IMAGE_HEIGHT:
                    n_cfg.image_height = pwdata[dcd_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold    <= dcd_pkg::RST_SCORE_THRESHOLD;
            r_cfg.inverse_scale      <= dcd_pkg::RST_INVERSE_SCALE;
            r_cfg.padding_horizontal <= dcd_pkg::RST_PADDING;
            r_cfg.padding_vertical   <= dcd_pkg::RST_PADDING;
            r_cfg.image_width        <= dcd_pkg::RST_IMAGE_DIM;
            r_cfg.image_height       <= dcd_pkg::RST_IMAGE_DIM;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            dcd_pkg::REG_SCORE_THRESHOLD:
                prdata = dcd_pkg::DATA_W'(r_cfg.score_threshold);
            dcd_pkg::REG_INVERSE_SCALE:
                prdata = dcd_pkg::DATA_W'(r_cfg.inverse_scale);
            dcd_pkg::REG_PADDING_HORIZONTAL:
                prdata = dcd_pkg::DATA_W'(r_cfg.padding_horizontal);
            dcd_pkg::REG_PADDING_VERTICAL:
                prdata = dcd_pkg::DATA_W'(r_cfg.padding_vertical);
            dcd_pkg::REG_IMAGE_WIDTH:
                prdata = dcd_pkg::DATA_W'(r_cfg.image_width);
            dcd_pkg::REG_IMAGE_HEIGHT:
                prdata = dcd_pkg::DATA_W'(r_cfg.image_height);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/dcd_argmax.sv =====
// Running class argmax and candidate register with threshold check.
`timescale 1ns / 1ps

module dcd_argmax #(
    parameter int MAX_CLASSES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dcd_cand_if.sink       i_cand,
    input  dcd_pkg::t_cfg  i_cfg,
    input  logic           i_a_free,
    output logic           o_va,
    output dcd_pkg::t_cand o_cand
);

    logic [dcd_pkg::SCORE_W-1:0]        r_best_score, n_best_score;
    logic signed [dcd_pkg::CLASS_W-1:0] r_best_class, n_best_class;
    logic [dcd_pkg::POS_W-1:0]          r_pos, n_pos;
    logic                               r_va, n_va;
    dcd_pkg::t_cand                     r_cand, n_cand;

    logic                               w_acc;
    logic                               w_upd;
    logic [dcd_pkg::SCORE_W-1:0]        w_cur_score;
    logic signed [dcd_pkg::CLASS_W-1:0] w_cur_class;
    logic [dcd_pkg::POS_W:0]            w_pos_inc;

    assign i_cand.ready = i_a_free;
    assign w_acc        = i_cand.valid && i_a_free;
    assign w_upd        = i_cand.class_score > r_best_score;
    assign w_cur_score  = w_upd ? i_cand.class_score : r_best_score;
    assign w_cur_class  = w_upd ? $signed({1'b0, r_pos}) : r_best_class;
    assign w_pos_inc    = {1'b0, r_pos} + (dcd_pkg::POS_W+1)'(1);

    always_comb begin
        n_best_score = r_best_score;
        n_best_class = r_best_class;
        n_pos        = r_pos;
        n_va         = r_va;
        n_cand       = r_cand;
        if (i_a_free) begin
            n_va = 1'b0;
        end
        if (w_acc) begin
            if (i_cand.last_class) begin
                n_best_score = '0;
                n_best_class = dcd_pkg::NO_CLASS;
                n_pos        = '0;
                n_va         = w_cur_score >= i_cfg.score_threshold;
                n_cand.kept_class = w_cur_class;
                n_cand.kept_score = w_cur_score;
                n_cand.centre_x   = i_cand.centre_x;
                n_cand.centre_y   = i_cand.centre_y;
                n_cand.box_w      = i_cand.box_w;
                n_cand.box_h      = i_cand.box_h;
            end else begin
                n_best_score = w_cur_score;
                n_best_class = w_cur_class;
                n_pos = (w_pos_inc >= (dcd_pkg::POS_W+1)'(MAX_CLASSES)) ? '0
                                                                      : w_pos_inc[dcd_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_class <= dcd_pkg::NO_CLASS;
            r_pos        <= '0;
            r_va         <= 1'b0;
        end else begin
            r_best_score <= n_best_score;
            r_best_class <= n_best_class;
            r_pos        <= n_pos;
            r_va         <= n_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    assign o_va   = r_va;
    assign o_cand = r_cand;

    a_zero_score_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_score == '0) == (r_best_class == dcd_pkg::NO_CLASS))
        else $error("running best class disagrees with running best score");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_cand.last_class |=> r_best_score == '0 && r_pos == '0)
        else $error("candidate close did not clear running argmax");

endmodule

// ===== hw/rtl/dcd_box.sv =====
// Box decode: corner products, clamp to image, pixel truncation, result register.
`timescale 1ns / 1ps

module dcd_box #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dcd_pkg::t_cfg  i_cfg,
    input  logic           i_va,
    input  dcd_pkg::t_cand i_cand,
    output logic           o_a_free,
    dcd_box_if.source      o_box
);

    localparam int OFF_W = dcd_pkg::PAD_W + COORD_FRAC_BITS;
    localparam int CW    = ((OFF_W > 18) ? OFF_W : 18) + 2;
    localparam int MW    = dcd_pkg::SCALE_W + 1;
    localparam int PW    = CW + MW;
    localparam int PF    = COORD_FRAC_BITS + 1 + dcd_pkg::SCALE_FRAC_BITS;
    localparam int EW    = dcd_pkg::PIX_W + PF;

    logic w_out_free, w_b_free;

    logic                               r_vb;
    logic signed [dcd_pkg::CLASS_W-1:0] r_b_class;
    logic [dcd_pkg::SCORE_W-1:0]        r_b_score;
    logic signed [PW-1:0]               r_px1, r_px2, r_py1, r_py2;
    logic signed [PW-1:0]               n_px1, n_px2, n_py1, n_py2;

    logic                               r_ov, n_ov;
    logic signed [dcd_pkg::CLASS_W-1:0] r_class;
    logic [dcd_pkg::SCORE_W-1:0]        r_score;
    logic [dcd_pkg::PIX_W-1:0]          r_left, r_top, r_width, r_height;
    logic [dcd_pkg::PIX_W-1:0]          n_left, n_top, n_width, n_height;

    logic [CW-1:0] w_x1, w_x2, w_y1, w_y2, w_offx, w_offy;
    logic signed [PW-1:0] w_inv;

    logic [dcd_pkg::PIX_W-1:0] w_wm1, w_hm1;
    logic [EW-1:0] w_ex1, w_ex2, w_ey1, w_ey2, w_dx, w_dy;

    function automatic logic [dcd_pkg::PIX_W-1:0] dim_m1(input logic [dcd_pkg::DIM_W-1:0] d);
        logic [dcd_pkg::DIM_W-1:0] e;
        e = (d == '0) ? dcd_pkg::DIM_W'(1) : ((d > dcd_pkg::DIM_MAX) ? dcd_pkg::DIM_MAX : d);
        return dcd_pkg::PIX_W'(e - dcd_pkg::DIM_W'(1));
    endfunction

    function automatic logic [EW-1:0] clamp(input logic signed [PW-1:0] v,
                                            input logic [dcd_pkg::PIX_W-1:0] m1);
        logic [PW-1:0] hi;
        hi = PW'(m1) << PF;
        if (v < 0) begin
            return '0;
        end else if ($unsigned(v) > hi) begin
            return EW'(hi);
        end else begin
            return EW'($unsigned(v));
        end
    endfunction

    assign w_out_free = !r_ov || o_box.ready;
    assign w_b_free   = !r_vb || w_out_free;
    assign o_a_free   = !i_va || w_b_free;

    // corners at F+1 fraction bits, half padding removed
    assign w_offx = CW'(i_cfg.padding_horizontal[dcd_pkg::PAD_W-1:1]) << (COORD_FRAC_BITS + 1);
    assign w_offy = CW'(i_cfg.padding_vertical[dcd_pkg::PAD_W-1:1]) << (COORD_FRAC_BITS + 1);
    assign w_x1 = CW'({i_cand.centre_x, 1'b0}) - CW'(i_cand.box_w) - w_offx;
    assign w_x2 = CW'({i_cand.centre_x, 1'b0}) + CW'(i_cand.box_w) - w_offx;
    assign w_y1 = CW'({i_cand.centre_y, 1'b0}) - CW'(i_cand.box_h) - w_offy;
    assign w_y2 = CW'({i_cand.centre_y, 1'b0}) + CW'(i_cand.box_h) - w_offy;
    assign w_inv = PW'($signed({1'b0, i_cfg.inverse_scale}));

    assign n_px1 = PW'($signed(w_x1)) * w_inv;
    assign n_px2 = PW'($signed(w_x2)) * w_inv;
    assign n_py1 = PW'($signed(w_y1)) * w_inv;
    assign n_py2 = PW'($signed(w_y2)) * w_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_b_free) begin
            r_vb <= i_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_free) begin
            r_b_class <= i_cand.kept_class;
            r_b_score <= i_cand.kept_score;
            r_px1     <= n_px1;
            r_px2     <= n_px2;
            r_py1     <= n_py1;
            r_py2     <= n_py2;
        end
    end

    assign w_wm1 = dim_m1(i_cfg.image_width);
    assign w_hm1 = dim_m1(i_cfg.image_height);
    assign w_ex1 = clamp(r_px1, w_wm1);
    assign w_ex2 = clamp(r_px2, w_wm1);
    assign w_ey1 = clamp(r_py1, w_hm1);
    assign w_ey2 = clamp(r_py2, w_hm1);
    assign w_dx  = (w_ex2 > w_ex1) ? w_ex2 - w_ex1 : '0;
    assign w_dy  = (w_ey2 > w_ey1) ? w_ey2 - w_ey1 : '0;

    assign n_left   = w_ex1[PF +: dcd_pkg::PIX_W];
    assign n_top    = w_ey1[PF +: dcd_pkg::PIX_W];
    assign n_width  = w_dx[PF +: dcd_pkg::PIX_W];
    assign n_height = w_dy[PF +: dcd_pkg::PIX_W];

    always_comb begin
        n_ov = r_ov;
        if (w_out_free) begin
            n_ov = r_vb && (n_width > dcd_pkg::PIX_W'(1)) && (n_height > dcd_pkg::PIX_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_class  <= r_b_class;
            r_score  <= r_b_score;
            r_left   <= n_left;
            r_top    <= n_top;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_box.valid      = r_ov;
    assign o_box.kept_class = r_class;
    assign o_box.kept_score = r_score;
    assign o_box.left_px    = r_left;
    assign o_box.top_px     = r_top;
    assign o_box.width_px   = r_width;
    assign o_box.height_px  = r_height;

    a_min_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_width > dcd_pkg::PIX_W'(1) && r_height > dcd_pkg::PIX_W'(1))
        else $error("emitted box narrower than two pixels");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_vb))
        else $error("result appeared without a product stage candidate");

endmodule

// ===== hw/rtl/detector_candidate_decode.sv =====
// Top level of the detector candidate decoder: class argmax and box decode.
//
//   channel  dir  transfer    payload
//   i_cand   in   valid/ready centre_x centre_y box_w box_h class_score last_class
//   o_box    out  valid/ready kept_class kept_score left_px top_px width_px height_px
//   apb      in   psel/penable/pwrite, pready tied high; six config registers at 4*i
//
// One class score is taken per cycle while i_cand.ready is high; the running argmax closes
// in the cycle of the transfer. After the last score of its candidate, a result passes through
// three registers: candidate register, corner product register, result register.
// Synchronous active-low reset clears valid bits and argmax state and loads config defaults.
// With o_box.ready low the three stages fill; i_cand.ready falls only when all hold.
`timescale 1ns / 1ps

module detector_candidate_decode #(
    parameter int MAX_CLASSES     = 256,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dcd_cand_if.sink                   i_cand,
    dcd_box_if.source                  o_box,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dcd_pkg::ADDR_W-1:0] paddr,
    input  logic [dcd_pkg::DATA_W-1:0] pwdata,
    output logic [dcd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    dcd_pkg::t_cfg  w_cfg;
    dcd_pkg::t_cand w_cand;
    logic           w_va;
    logic           w_a_free;

    dcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dcd_argmax #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_argmax (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cand   (i_cand),
        .i_cfg    (w_cfg),
        .i_a_free (w_a_free),
        .o_va     (w_va),
        .o_cand   (w_cand)
    );

    dcd_box #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_va     (w_va),
        .i_cand   (w_cand),
        .o_a_free (w_a_free),
        .o_box    (o_box)
    );

endmodule
